>>> design/lsg_pkg.sv
package lsg_pkg;

  // Default coordinate width, signed Q10 metres.
  localparam int COORD_BITS_DEF = 20;

  // Range result width and its saturation value.
  localparam int RANGE_BITS = 20;
  localparam logic [RANGE_BITS-1:0] RANGE_MAX = '1;

  // Configuration register widths.
  localparam int BAND_W     = 19;
  localparam int SLOPE_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;
  localparam int INTEN_W    = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Y_BAND      = 3'd0,
    REG_OUTER_UPPER = 3'd1,
    REG_OUTER_LOWER = 3'd2,
    REG_INNER_UPPER = 3'd3,
    REG_INNER_LOWER = 3'd4,
    REG_DEV_START   = 3'd5
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [BAND_W-1:0]         Y_BAND_RST    = 19'd154;
  localparam logic signed [SLOPE_W-1:0] OU_SLOPE_RST  = 17'sd4583;
  localparam logic signed [SLOPE_W-1:0] OL_SLOPE_RST  = -17'sd2288;
  localparam logic signed [SLOPE_W-1:0] IU_SLOPE_RST  = 17'sd2288;
  localparam logic signed [SLOPE_W-1:0] IL_SLOPE_RST  = 17'sd0;
  localparam logic [BAND_W-1:0]         DEV_START_RST = 19'd10240;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic mul;
    logic gate;
    logic square;
    logic sum_sq;
    logic root;
    logic emit;
  } lsg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_item;
    logic root_done;
    logic out_free;
  } lsg_sts_t;

  // Input tdata width: x, y, z and intensity rounded up to whole bytes.
  function automatic int in_data_w(input int cb);
    return ((3 * cb + INTEN_W + 7) / 8) * 8;
  endfunction

  // Output tdata width: x, y, z, range and intensity rounded up to whole bytes.
  function automatic int out_data_w(input int cb);
    return ((3 * cb + RANGE_BITS + INTEN_W + 7) / 8) * 8;
  endfunction

endpackage

>>> design/lsg_ctrl.sv
module lsg_ctrl import lsg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  lsg_sts_t sts,
  output lsg_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_GATE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Commands follow from the current state; load_in and emit also need in_tvalid and out_free.
  always_comb begin
    cmd         = '0;
    cmd.load_in = (state_r == ST_IDLE) && in_tvalid;
    cmd.mul     = (state_r == ST_MULT);
    cmd.gate    = (state_r == ST_GATE);
    cmd.square  = (state_r == ST_SQUARE);
    cmd.sum_sq  = (state_r == ST_SUM);
    cmd.root    = (state_r == ST_ROOT);
    cmd.emit    = (state_r == ST_EMIT) && sts.out_free;
  end

  assign in_tready = (state_r == ST_IDLE);

  // Sequencing of one point; the frame end runs the square root.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MULT;
      end
      ST_MULT:   state_nxt = ST_GATE;
      ST_GATE: begin
        state_nxt = sts.last_item ? ST_SQUARE : ST_EMIT;
      end
      ST_SQUARE: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (sts.root_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/lsg_datapath.sv
module lsg_datapath import lsg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_data,
  input  logic [in_data_w(COORD_BITS)-1:0]    in_tdata,
  input  logic                                in_tlast,
  input  lsg_cmd_t                            cmd,
  output lsg_sts_t                            sts,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [out_data_w(COORD_BITS)-1:0]   out_tdata,
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast
);

  localparam int CB     = COORD_BITS;
  localparam int OUT_W  = out_data_w(COORD_BITS);
  localparam int PROD_W = CB + SLOPE_W;
  localparam int DEV_W  = (CB > BAND_W) ? CB : BAND_W;
  localparam int SQ_W   = 2 * CB;
  localparam int SUM_W  = (2 * CB + 2 > 64) ? 64 : 2 * CB + 2;
  localparam int R_W    = SUM_W / 2;
  localparam int REM_W  = R_W + 2;
  localparam int ITER_W = $clog2(R_W);
  localparam int RX_W   = (R_W > RANGE_BITS) ? R_W : RANGE_BITS;

  // Configuration registers.
  logic [BAND_W-1:0]         y_band_r;
  logic signed [SLOPE_W-1:0] ou_slope_r;
  logic signed [SLOPE_W-1:0] ol_slope_r;
  logic signed [SLOPE_W-1:0] iu_slope_r;
  logic signed [SLOPE_W-1:0] il_slope_r;
  logic [BAND_W-1:0]         dev_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_band_r    <= Y_BAND_RST;
      ou_slope_r  <= OU_SLOPE_RST;
      ol_slope_r  <= OL_SLOPE_RST;
      iu_slope_r  <= IU_SLOPE_RST;
      il_slope_r  <= IL_SLOPE_RST;
      dev_start_r <= DEV_START_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_Y_BAND:      y_band_r    <= cfg_data[BAND_W-1:0];
        REG_OUTER_UPPER: ou_slope_r  <= $signed(cfg_data[SLOPE_W-1:0]);
        REG_OUTER_LOWER: ol_slope_r  <= $signed(cfg_data[SLOPE_W-1:0]);
        REG_INNER_UPPER: iu_slope_r  <= $signed(cfg_data[SLOPE_W-1:0]);
        REG_INNER_LOWER: il_slope_r  <= $signed(cfg_data[SLOPE_W-1:0]);
        REG_DEV_START:   dev_start_r <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured input point.
  logic signed [CB-1:0] x_r, y_r, z_r;
  logic [INTEN_W-1:0]   int_r;
  logic                 last_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r    <= $signed(in_tdata[CB-1:0]);
      y_r    <= $signed(in_tdata[2*CB-1:CB]);
      z_r    <= $signed(in_tdata[3*CB-1:2*CB]);
      int_r  <= in_tdata[3*CB+INTEN_W-1:3*CB];
      last_r <= in_tlast;
    end
  end

  // Slope products x * tan, one multiplier per threshold.
  logic signed [PROD_W-1:0] prod_ou_r, prod_ol_r, prod_iu_r, prod_il_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_ou_r <= PROD_W'(x_r) * PROD_W'(ou_slope_r);
      prod_ol_r <= PROD_W'(x_r) * PROD_W'(ol_slope_r);
      prod_iu_r <= PROD_W'(x_r) * PROD_W'(iu_slope_r);
      prod_il_r <= PROD_W'(x_r) * PROD_W'(il_slope_r);
    end
  end

  // Gate tests on the registered products.
  logic signed [PROD_W-1:0] zs;
  logic [CB-1:0]            y_u;
  logic [CB-1:0]            ay;
  logic                     x_pos;
  logic                     kept;
  logic                     inner;
  logic                     better;

  assign zs     = {z_r[CB-1], z_r, 16'b0};
  assign y_u    = y_r;
  assign ay     = y_u[CB-1] ? (~y_u + 1'b1) : y_u;
  assign x_pos  = !x_r[CB-1] && (x_r != '0);
  assign kept   = x_pos && (zs < prod_ou_r) && (zs > prod_ol_r)
                  && (DEV_W'(ay) <= DEV_W'(y_band_r));
  assign inner  = (zs < prod_iu_r) && (zs > prod_il_r);

  // Search state and the frame snapshot taken at the frame end.
  logic [DEV_W-1:0]     best_dev_r;
  logic signed [CB-1:0] best_x_r, best_y_r, best_z_r;
  logic [INTEN_W-1:0]   best_int_r;
  logic                 have_best_r;
  logic signed [CB-1:0] snap_x_r, snap_y_r, snap_z_r;
  logic [INTEN_W-1:0]   snap_int_r;
  logic                 snap_found_r;

  assign better = kept && inner && (DEV_W'(ay) < best_dev_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dev_r  <= DEV_W'(DEV_START_RST);
      best_x_r    <= '0;
      best_y_r    <= '0;
      best_z_r    <= '0;
      best_int_r  <= '0;
      have_best_r <= 1'b0;
    end else if (cmd.gate) begin
      if (last_r) begin
        best_dev_r  <= DEV_W'(dev_start_r);
        best_x_r    <= '0;
        best_y_r    <= '0;
        best_z_r    <= '0;
        best_int_r  <= '0;
        have_best_r <= 1'b0;
      end else if (better) begin
        best_dev_r  <= DEV_W'(ay);
        best_x_r    <= x_r;
        best_y_r    <= y_r;
        best_z_r    <= z_r;
        best_int_r  <= int_r;
        have_best_r <= 1'b1;
      end
    end
  end

  // Per-point result fields and the frame snapshot.
  logic                 res_kept_r;
  logic signed [CB-1:0] res_x_r, res_y_r, res_z_r;
  logic                 res_last_r;

  always_ff @(posedge clk) begin
    if (cmd.gate) begin
      res_kept_r <= kept;
      res_x_r    <= kept ? x_r : '0;
      res_y_r    <= kept ? y_r : '0;
      res_z_r    <= kept ? z_r : '0;
      res_last_r <= last_r;
      if (last_r) begin
        snap_x_r     <= better ? x_r : best_x_r;
        snap_y_r     <= better ? y_r : best_y_r;
        snap_z_r     <= better ? z_r : best_z_r;
        snap_int_r   <= better ? int_r : best_int_r;
        snap_found_r <= better || have_best_r;
      end
    end
  end

  // Squares of the selected point's magnitudes.
  logic [CB-1:0]   sx_u, sy_u, sz_u;
  logic [CB-1:0]   ax, ayb, az;
  logic [SQ_W-1:0] sqx_r, sqy_r, sqz_r;

  assign sx_u = snap_x_r;
  assign sy_u = snap_y_r;
  assign sz_u = snap_z_r;
  assign ax   = sx_u[CB-1] ? (~sx_u + 1'b1) : sx_u;
  assign ayb  = sy_u[CB-1] ? (~sy_u + 1'b1) : sy_u;
  assign az   = sz_u[CB-1] ? (~sz_u + 1'b1) : sz_u;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sqx_r <= SQ_W'(ax) * SQ_W'(ax);
      sqy_r <= SQ_W'(ayb) * SQ_W'(ayb);
      sqz_r <= SQ_W'(az) * SQ_W'(az);
    end
  end

  // Digit-by-digit square root, two radicand bits per cycle.
  logic [SUM_W-1:0]  sum_r;
  logic [REM_W-1:0]  rem_r;
  logic [R_W-1:0]    root_r;
  logic [ITER_W-1:0] iter_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  assign rem_sh = {rem_r[REM_W-3:0], sum_r[SUM_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sum_sq) begin
      sum_r  <= SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);
      rem_r  <= '0;
      root_r <= '0;
      iter_r <= ITER_W'(R_W - 1);
    end else if (cmd.root) begin
      sum_r  <= sum_r << 2;
      iter_r <= iter_r - 1'b1;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[R_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[R_W-2:0], 1'b0};
      end
    end
  end

  // Saturate the root to the range field.
  logic [RX_W-1:0]       root_ext;
  logic [RANGE_BITS-1:0] range_sat;

  assign root_ext  = RX_W'(root_r);
  assign range_sat = (root_ext > RX_W'(RANGE_MAX)) ? RANGE_MAX
                                                   : root_ext[RANGE_BITS-1:0];

  // Output register; it holds a result until the transfer completes.
  logic                  out_valid_r;
  logic                  o_kept_r, o_found_r, o_last_r;
  logic signed [CB-1:0]  o_x_r, o_y_r, o_z_r;
  logic [RANGE_BITS-1:0] o_range_r;
  logic [INTEN_W-1:0]    o_int_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_kept_r  <= res_kept_r;
      o_x_r     <= res_x_r;
      o_y_r     <= res_y_r;
      o_z_r     <= res_z_r;
      o_last_r  <= res_last_r;
      o_found_r <= res_last_r && snap_found_r;
      o_range_r <= res_last_r ? range_sat : '0;
      o_int_r   <= res_last_r ? snap_int_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({o_int_r, o_range_r, o_z_r, o_y_r, o_x_r});
  assign out_tuser  = {o_found_r, o_kept_r};
  assign out_tlast  = o_last_r;

  // Status back to the controller.
  assign sts.last_item = last_r;
  assign sts.root_done = (iter_r == '0);
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

>>> design/lidar_sector_gate_nearest_point_top.sv
// Channel | Direction | Handshake           | Content
// in_     | input     | in_tvalid/in_tready | one lidar point, frame end on in_tlast
// out_    | output    | out_tvalid/out_tready | gate result, frame summary on out_tlast
// cfg_    | input     | cfg_valid/cfg_ready | register index and write data
//
// A point inside a frame is accepted in idle and then passes the multiply, gate and emit states;
// its result is registered in emit once the output register is free. A frame-end point passes
// square, sum and root after gate, with R = min(COORD_BITS + 1, 32) square root steps of two radicand bits each.
// Synchronous active-low reset restores register defaults and clears the search.
// The output register holds its result until taken; the next point is accepted meanwhile,
// and the block waits before its own write-back while the earlier result is still pending.
module lidar_sector_gate_nearest_point_top import lsg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: px, py, pz, intensity_in, zero fill.
  input  logic [in_data_w(COORD_BITS)-1:0]  in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: kept_x, kept_y, kept_z, range_out, best_intensity, zero fill.
  output logic [out_data_w(COORD_BITS)-1:0] out_tdata,
  // Fields from bit 0: kept, found.
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data
);

  lsg_cmd_t cmd;
  lsg_sts_t sts;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  lsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsg_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  // One point at a time: an accepted transfer closes the input.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again while a point is in work");

  // Summary fields stay zero on points that do not end a frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tuser[1]
      && (out_tdata[3*COORD_BITS+RANGE_BITS+INTEN_W-1:3*COORD_BITS] == '0))
    else $error("frame summary set on a point inside the frame");

  // A kept point always has positive x.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tdata[COORD_BITS-1]
      && (out_tdata[COORD_BITS-1:0] != '0))
    else $error("kept point with x not positive");
`endif

endmodule
